// ----- rtl/vrsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrsu_pkg: shared types and constants of the video register scroll unit
// Command codes, register port numbers and address constants.
// ----------------------------------------------------------------------------
package vrsu_pkg;

	localparam int OBJECT_TABLE_DEPTH = 256;

	typedef enum logic [3:0] {
		CMD_REG_WRITE   = 4'd0,
		CMD_REG_READ    = 4'd1,
		CMD_STEP_X      = 4'd2,
		CMD_STEP_Y      = 4'd3,
		CMD_COPY_HORIZ  = 4'd4,
		CMD_VBLANK_ON   = 4'd5,
		CMD_VBLANK_OFF  = 4'd6,
		CMD_SPRITE_HIT  = 4'd7,
		CMD_NMI_SET     = 4'd8
	} cmd_t;

	localparam logic [2:0] PORT_CTRL     = 3'd0;
	localparam logic [2:0] PORT_MASK     = 3'd1;
	localparam logic [2:0] PORT_STATUS   = 3'd2;
	localparam logic [2:0] PORT_OBJ_ADDR = 3'd3;
	localparam logic [2:0] PORT_OBJ_DATA = 3'd4;
	localparam logic [2:0] PORT_SCROLL   = 3'd5;
	localparam logic [2:0] PORT_ADDR     = 3'd6;
	localparam logic [2:0] PORT_DATA     = 3'd7;

	localparam logic [13:0] PALETTE_BASE   = 14'h3F00;
	localparam logic [13:0] PALETTE_MIRROR = 14'h1000;
	localparam logic [4:0]  COARSE_Y_LAST  = 5'd29;
	localparam logic [15:0] ADDR_STEP_ROW  = 16'd32;
	localparam logic [15:0] ADDR_STEP_ONE  = 16'd1;

endpackage
`default_nettype wire

// ----- rtl/video_register_scroll_unit_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_register_scroll_unit_core: register and scroll-address unit
// CPU register ports, scroll counters, status flags and object table of a
// tile video processor, one command per transaction.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    command, reg_index, write_data,
//                                                 flag_value, vram_read_data
// result    out        result_valid / result_stall read_data, fetch_addr,
//                                                 mem_write_en, mem_write_addr,
//                                                 mem_write_data, nmi_request,
//                                                 fine_x_out, fine_y_out, current_addr
//
// One transaction per clock unless the result register is stalled; each item
//   is captured in the input register and moves into the result register once
//   that register can take it. The object table read port sets the input
//   register stage: its registered read is taken as the item is captured.
// Reset: arst_n clears all architectural registers and both valid flags; the
//   object table is not cleared.
// Stalls: result_stall holds the result register; the input register then
//   holds too and item_stall rises once it is occupied.
// ----------------------------------------------------------------------------
module video_register_scroll_unit_core #(
	parameter int OBJECT_TABLE_DEPTH = vrsu_pkg::OBJECT_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// item channel
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [3:0]  command,
	input  wire logic [2:0]  reg_index,
	input  wire logic [7:0]  write_data,
	input  wire logic        flag_value,
	input  wire logic [7:0]  vram_read_data,
	// result channel
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       read_data,
	output logic [13:0]      fetch_addr,
	output logic             mem_write_en,
	output logic [15:0]      mem_write_addr,
	output logic [7:0]       mem_write_data,
	output logic             nmi_request,
	output logic [2:0]       fine_x_out,
	output logic [2:0]       fine_y_out,
	output logic [15:0]      current_addr
);

	localparam int OBJ_IDX_W = $clog2(OBJECT_TABLE_DEPTH);

	// ------------------------------------------------------------------
	// Input register stage
	// ------------------------------------------------------------------
	logic       s1_valid_q;
	logic [3:0] cmd_s1;
	logic [2:0] port_s1;
	logic [7:0] wdata_s1;
	logic       flag_s1;
	logic [7:0] vram_s1;
	logic [7:0] obj_rd_s1;

	logic       res_valid_q;
	logic       s1_exec;
	logic       item_take;

	// Execute the captured item whenever the result register can take it.
	assign s1_exec    = s1_valid_q & ~(res_valid_q & result_stall);
	assign item_stall = s1_valid_q & ~s1_exec;
	assign item_take  = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_exec) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			cmd_s1   <= command;
			port_s1  <= reg_index;
			wdata_s1 <= write_data;
			flag_s1  <= flag_value;
			vram_s1  <= vram_read_data;
		end
	end

	// ------------------------------------------------------------------
	// Architectural state
	// ------------------------------------------------------------------
	logic        ctrl_inc_q;      // control byte bit 2: data port step of 32
	logic        ctrl_nmi_q;      // control byte bit 7: raise nmi at vblank
	logic        stat_vbl_q;      // status bit 7
	logic        stat_hit_q;      // status bit 6, the sprite-hit flag
	logic [7:0]  obj_addr_q;
	logic [15:0] temp_addr_q;
	logic [15:0] cur_addr_q;
	logic [2:0]  fine_x_q;
	logic [2:0]  fine_y_q;
	logic        toggle_q;
	logic [7:0]  rbuf_q;
	logic        nmi_q;

	logic        ctrl_inc_n;
	logic        ctrl_nmi_n;
	logic        stat_vbl_n;
	logic        stat_hit_n;
	logic [7:0]  obj_addr_n;
	logic [15:0] temp_addr_n;
	logic [15:0] cur_addr_n;
	logic [2:0]  fine_x_n;
	logic [2:0]  fine_y_n;
	logic        toggle_n;
	logic [7:0]  rbuf_n;
	logic        nmi_n;

	logic [7:0]  rd_n;
	logic        we_n;
	logic [15:0] wa_n;
	logic [7:0]  wd_n;
	logic        obj_we;
	logic [13:0] fetch_n;

	logic [15:0] addr_step;
	logic        pal_hit;
	logic [2:0]  fx_inc;
	logic [4:0]  cx_inc;
	logic [2:0]  fy_inc;
	logic [4:0]  cy_cur;
	logic [4:0]  cy_inc;

	assign addr_step = ctrl_inc_q ? vrsu_pkg::ADDR_STEP_ROW : vrsu_pkg::ADDR_STEP_ONE;
	assign pal_hit   = (cur_addr_q[13:0] >= vrsu_pkg::PALETTE_BASE);
	assign fx_inc    = fine_x_q + 3'd1;
	assign cx_inc    = cur_addr_q[4:0] + 5'd1;
	assign fy_inc    = cur_addr_q[14:12] + 3'd1;
	assign cy_cur    = cur_addr_q[9:5];
	// Coarse Y wraps at 30 rows; the two rows past the end fold back to 1 and 2.
	assign cy_inc    = (cy_cur >= vrsu_pkg::COARSE_Y_LAST) ?
		(cy_cur - vrsu_pkg::COARSE_Y_LAST) : (cy_cur + 5'd1);

	always_comb begin
		ctrl_inc_n  = ctrl_inc_q;
		ctrl_nmi_n  = ctrl_nmi_q;
		stat_vbl_n  = stat_vbl_q;
		stat_hit_n  = stat_hit_q;
		obj_addr_n  = obj_addr_q;
		temp_addr_n = temp_addr_q;
		cur_addr_n  = cur_addr_q;
		fine_x_n    = fine_x_q;
		fine_y_n    = fine_y_q;
		toggle_n    = toggle_q;
		rbuf_n      = rbuf_q;
		nmi_n       = nmi_q;
		rd_n        = 8'd0;
		we_n        = 1'b0;
		wa_n        = 16'd0;
		wd_n        = 8'd0;
		obj_we      = 1'b0;

		case (cmd_s1)
			vrsu_pkg::CMD_REG_WRITE: begin
				case (port_s1)
					vrsu_pkg::PORT_CTRL: begin
						ctrl_inc_n         = wdata_s1[2];
						ctrl_nmi_n         = wdata_s1[7];
						temp_addr_n[11:10] = wdata_s1[1:0];
					end
					vrsu_pkg::PORT_OBJ_ADDR: begin
						obj_addr_n = wdata_s1;
					end
					vrsu_pkg::PORT_OBJ_DATA: begin
						obj_we = 1'b1;
					end
					vrsu_pkg::PORT_SCROLL: begin
						if (!toggle_q) begin
							temp_addr_n[15]  = 1'b0;
							temp_addr_n[4:0] = wdata_s1[7:3];
							fine_x_n         = wdata_s1[2:0];
						end else begin
							temp_addr_n[15]    = 1'b0;
							temp_addr_n[14:12] = wdata_s1[2:0];
							temp_addr_n[9:5]   = wdata_s1[7:3];
						end
						toggle_n = ~toggle_q;
					end
					vrsu_pkg::PORT_ADDR: begin
						if (!toggle_q) begin
							temp_addr_n[15:8] = {2'b00, wdata_s1[5:0]};
						end else begin
							temp_addr_n[15]   = 1'b0;
							temp_addr_n[7:0]  = wdata_s1;
							cur_addr_n        = temp_addr_n;
						end
						toggle_n = ~toggle_q;
					end
					vrsu_pkg::PORT_DATA: begin
						we_n       = 1'b1;
						wa_n       = cur_addr_q;
						wd_n       = wdata_s1;
						cur_addr_n = cur_addr_q + addr_step;
					end
					default: begin
					end
				endcase
			end
			vrsu_pkg::CMD_REG_READ: begin
				case (port_s1)
					vrsu_pkg::PORT_STATUS: begin
						rd_n       = {stat_vbl_q, stat_hit_q, 6'd0};
						stat_vbl_n = 1'b0;
						toggle_n   = 1'b0;
					end
					vrsu_pkg::PORT_OBJ_DATA: begin
						rd_n = obj_rd_s1;
					end
					vrsu_pkg::PORT_DATA: begin
						// Palette reads bypass the buffer; all others return the old buffer.
						rd_n       = pal_hit ? vram_s1 : rbuf_q;
						rbuf_n     = vram_s1;
						cur_addr_n = cur_addr_q + addr_step;
					end
					default: begin
					end
				endcase
			end
			vrsu_pkg::CMD_STEP_X: begin
				fine_x_n = fx_inc;
				if (fx_inc == 3'd0) begin
					cur_addr_n[4:0] = cx_inc;
					if (cx_inc == 5'd0) begin
						cur_addr_n[10] = ~cur_addr_q[10];
					end
				end
			end
			vrsu_pkg::CMD_STEP_Y: begin
				fine_y_n           = fy_inc;
				cur_addr_n[15]     = 1'b0;
				cur_addr_n[14:12]  = fy_inc;
				if (fy_inc == 3'd0) begin
					cur_addr_n[9:5] = cy_inc;
					if (cy_cur == vrsu_pkg::COARSE_Y_LAST) begin
						cur_addr_n[11] = ~cur_addr_q[11];
					end
				end
			end
			vrsu_pkg::CMD_COPY_HORIZ: begin
				cur_addr_n[10]  = temp_addr_q[10];
				cur_addr_n[4:0] = temp_addr_q[4:0];
			end
			vrsu_pkg::CMD_VBLANK_ON: begin
				stat_vbl_n = 1'b1;
				if (ctrl_nmi_q) begin
					nmi_n = 1'b1;
				end
			end
			vrsu_pkg::CMD_VBLANK_OFF: begin
				stat_vbl_n = 1'b0;
				stat_hit_n = 1'b0;
			end
			vrsu_pkg::CMD_SPRITE_HIT: begin
				stat_hit_n = flag_s1;
			end
			vrsu_pkg::CMD_NMI_SET: begin
				nmi_n = flag_s1;
			end
			default: begin
			end
		endcase
	end

	// Palette addresses fetch from the mirror PALETTE_MIRROR (14'h1000) below.
	assign fetch_n = (cur_addr_n[13:0] >= vrsu_pkg::PALETTE_BASE) ?
		(cur_addr_n[13:0] - vrsu_pkg::PALETTE_MIRROR) : cur_addr_n[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_inc_q  <= 1'b0;
			ctrl_nmi_q  <= 1'b0;
			stat_vbl_q  <= 1'b0;
			stat_hit_q  <= 1'b0;
			obj_addr_q  <= 8'd0;
			temp_addr_q <= 16'd0;
			cur_addr_q  <= 16'd0;
			fine_x_q    <= 3'd0;
			fine_y_q    <= 3'd0;
			toggle_q    <= 1'b0;
			rbuf_q      <= 8'd0;
			nmi_q       <= 1'b0;
		end else if (s1_exec) begin
			ctrl_inc_q  <= ctrl_inc_n;
			ctrl_nmi_q  <= ctrl_nmi_n;
			stat_vbl_q  <= stat_vbl_n;
			stat_hit_q  <= stat_hit_n;
			obj_addr_q  <= obj_addr_n;
			temp_addr_q <= temp_addr_n;
			cur_addr_q  <= cur_addr_n;
			fine_x_q    <= fine_x_n;
			fine_y_q    <= fine_y_n;
			toggle_q    <= toggle_n;
			rbuf_q      <= rbuf_n;
			nmi_q       <= nmi_n;
		end
	end

	// ------------------------------------------------------------------
	// Object table: one write port, one registered read port. The read is
	// taken as an item is captured, at the object address the executing
	// item leaves behind; a table write by that item is forwarded.
	// ------------------------------------------------------------------
	logic [7:0] obj_mem_q [OBJECT_TABLE_DEPTH];
	logic [OBJ_IDX_W-1:0] obj_wr_idx;
	logic [OBJ_IDX_W-1:0] obj_rd_idx;
	logic                 obj_fwd;

	assign obj_wr_idx = obj_addr_q[OBJ_IDX_W-1:0];
	assign obj_rd_idx = s1_exec ? obj_addr_n[OBJ_IDX_W-1:0] : obj_addr_q[OBJ_IDX_W-1:0];
	assign obj_fwd    = s1_exec & obj_we;

	always_ff @(posedge clk) begin
		if (s1_exec && obj_we) begin
			obj_mem_q[obj_wr_idx] <= wdata_s1;
		end
		if (item_take) begin
			obj_rd_s1 <= obj_fwd ? wdata_s1 : obj_mem_q[obj_rd_idx];
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [7:0]  res_rd_q;
	logic [13:0] res_fetch_q;
	logic        res_we_q;
	logic [15:0] res_wa_q;
	logic [7:0]  res_wd_q;
	logic        res_nmi_q;
	logic [2:0]  res_fx_q;
	logic [2:0]  res_fy_q;
	logic [15:0] res_cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_exec) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_exec) begin
			res_rd_q    <= rd_n;
			res_fetch_q <= fetch_n;
			res_we_q    <= we_n;
			res_wa_q    <= wa_n;
			res_wd_q    <= wd_n;
			res_nmi_q   <= nmi_n;
			res_fx_q    <= fine_x_n;
			res_fy_q    <= fine_y_n;
			res_cur_q   <= cur_addr_n;
		end
	end

	assign result_valid   = res_valid_q;
	assign read_data      = res_rd_q;
	assign fetch_addr     = res_fetch_q;
	assign mem_write_en   = res_we_q;
	assign mem_write_addr = res_wa_q;
	assign mem_write_data = res_wd_q;
	assign nmi_request    = res_nmi_q;
	assign fine_x_out     = res_fx_q;
	assign fine_y_out     = res_fy_q;
	assign current_addr   = res_cur_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid_q && res_valid_q && result_stall))
		else $error("item_stall raised without a blocked input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_exec) |=> (s1_valid_q && $stable(cmd_s1) && $stable(wdata_s1)))
		else $error("blocked input register lost its item");

	a_step_y_fine: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_exec && cmd_s1 == vrsu_pkg::CMD_STEP_Y) |=>
		(result_valid && fine_y_out == current_addr[14:12] && !current_addr[15]))
		else $error("vertical step left fine Y out of step with the address");

	a_data_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_exec && cmd_s1 == vrsu_pkg::CMD_REG_WRITE && port_s1 == vrsu_pkg::PORT_DATA) |=>
		(result_valid && mem_write_en))
		else $error("data port write produced no memory write");

endmodule
`default_nettype wire
